[src/crl_pkg.sv]
// crl_pkg: shared types, opcodes and defaults for the circular record log
`timescale 1ns / 1ps

package crl_pkg;

   // default ring depth
   localparam int CRL_LOG_DEPTH = 5;

   // request opcodes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // one stored record, 45 bits
   typedef struct packed {
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [4:0]  hours;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] sample_raw;
      logic [6:0]  sample_percent;
   } rec_type;

   // request payload
   typedef struct packed {
      logic        opcode;
      logic [5:0]  read_slot;
      logic [5:0]  in_seconds;
      logic [5:0]  in_minutes;
      logic [4:0]  in_hours;
      logic [4:0]  in_day;
      logic [3:0]  in_month;
      logic [11:0] in_sample_raw;
      logic [6:0]  in_sample_percent;
   } req_type;

   // response payload
   typedef struct packed {
      logic [5:0]  out_seconds;
      logic [5:0]  out_minutes;
      logic [4:0]  out_hours;
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [11:0] out_sample_raw;
      logic [6:0]  out_sample_percent;
      logic [6:0]  valid_count;
      logic        log_empty;
   } rsp_type;

   // memory port strobes from the pointer logic
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

[src/crl_ring_mem.sv]
// crl_ring_mem: record storage, one write or one registered read per cycle
`timescale 1ns / 1ps

module crl_ring_mem import crl_pkg::*; #(
   parameter int LOG_DEPTH = CRL_LOG_DEPTH,
   localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1
) (
   input  logic        clock,
   input  mem_cmd_type mem_cmd,
   input  logic [AW-1:0] mem_addr,
   input  rec_type     wr_data,
   output rec_type     rd_data
);

   rec_type mem_ff [LOG_DEPTH];
   rec_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem_ff[mem_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem_ff[mem_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/crl_ptr.sv]
// crl_ptr: head and count registers and the record address for each request
`timescale 1ns / 1ps

module crl_ptr import crl_pkg::*; #(
   parameter int LOG_DEPTH = CRL_LOG_DEPTH,
   localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1,
   localparam int CW = $clog2(LOG_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic          opcode,
   input  logic [5:0]    read_slot,
   output mem_cmd_type   mem_cmd,
   output logic [AW-1:0] mem_addr,
   output logic [CW-1:0] count_after,
   output logic          read_empty
);

   localparam int WW = (CW + 1 > 7) ? CW + 1 : 7;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in, count_inc;
   logic [WW-1:0] slot_w, count_w, clamp_w, pos_sum, pos_wrap;
   logic          is_append;

   // age slot to ring position, clamped to the newest record
   always_comb begin
      count_w  = WW'(count_ff);
      slot_w   = WW'(read_slot);
      clamp_w  = (slot_w >= count_w) ? count_w - WW'(1) : slot_w;
      pos_sum  = WW'(head_ff) + WW'(LOG_DEPTH) - count_w + clamp_w;
      pos_wrap = (pos_sum >= WW'(LOG_DEPTH)) ? pos_sum - WW'(LOG_DEPTH) : pos_sum;
   end

   // memory command
   always_comb begin
      is_append     = (opcode == OP_APPEND);
      read_empty    = (count_ff == '0);
      mem_addr      = is_append ? head_ff : pos_wrap[AW-1:0];
      mem_cmd.wr_en = accept && is_append;
      mem_cmd.rd_en = accept && !is_append && !read_empty;
   end

   // head wraps, count saturates at the depth
   always_comb begin
      count_inc   = (count_ff == CW'(LOG_DEPTH)) ? count_ff : count_ff + CW'(1);
      count_after = is_append ? count_inc : count_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      if (accept && is_append) begin
         head_in  = (head_ff == AW'(LOG_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/circular_record_log.sv]
// circular_record_log: top level of the overwrite-oldest record ring
//
//  channel | ports                         | direction | moves
//  --------+-------------------------------+-----------+--------------------------
//  req     | req_valid req_ready req_data  | in        | append or read request
//  rsp     | rsp_valid rsp_ready rsp_data  | out       | one result per request
//
// A request is taken at the handshake: appends write the memory, reads issue the
// memory read. The result is formed the next cycle from the registered read
// data and sits in the output register. The sustained rate is one request per
// cycle while the output is not stalled, set by the single memory port.
// Reset clears head and count; the record memory is not cleared.
// A stalled result holds one more request in the pending stage, then
// req_ready drops.
`timescale 1ns / 1ps

module circular_record_log import crl_pkg::*; #(
   parameter int LOG_DEPTH = CRL_LOG_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CW = $clog2(LOG_DEPTH + 1);

   mem_cmd_type   mem_cmd;
   logic [AW-1:0] mem_addr;
   logic [CW-1:0] count_after;
   logic          read_empty;
   rec_type       wr_rec, rd_rec;

   logic          req_accept, rsp_free, pend_move;
   logic          pend_ff, pend_in;
   logic          pend_read_ff, pend_empty_ff;
   logic [CW-1:0] pend_count_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // handshake
   always_comb begin
      rsp_free   = !rsp_valid_ff || rsp_ready;
      pend_move  = pend_ff && rsp_free;
      req_ready  = !pend_ff || rsp_free;
      req_accept = req_valid && req_ready;
   end

   // record to store on append
   always_comb begin
      wr_rec.seconds        = req_data.in_seconds;
      wr_rec.minutes        = req_data.in_minutes;
      wr_rec.hours          = req_data.in_hours;
      wr_rec.day            = req_data.in_day;
      wr_rec.month          = req_data.in_month;
      wr_rec.sample_raw     = req_data.in_sample_raw;
      wr_rec.sample_percent = req_data.in_sample_percent;
   end

   crl_ptr #(.LOG_DEPTH(LOG_DEPTH)) u_ptr (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .opcode      (req_data.opcode),
      .read_slot   (req_data.read_slot),
      .mem_cmd     (mem_cmd),
      .mem_addr    (mem_addr),
      .count_after (count_after),
      .read_empty  (read_empty)
   );

   crl_ring_mem #(.LOG_DEPTH(LOG_DEPTH)) u_mem (
      .clock    (clock),
      .mem_cmd  (mem_cmd),
      .mem_addr (mem_addr),
      .wr_data  (wr_rec),
      .rd_data  (rd_rec)
   );

   // pending stage waits for the read data
   always_comb begin
      pend_in = pend_ff;
      if (req_accept) begin
         pend_in = 1'b1;
      end else if (pend_move) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_read_ff  <= (req_data.opcode == OP_READ);
         pend_empty_ff <= read_empty;
         pend_count_ff <= count_after;
      end
   end

   // result: record fields only for a read that found records
   always_comb begin
      rsp_in = '0;
      if (pend_read_ff && !pend_empty_ff) begin
         rsp_in.out_seconds        = rd_rec.seconds;
         rsp_in.out_minutes        = rd_rec.minutes;
         rsp_in.out_hours          = rd_rec.hours;
         rsp_in.out_day            = rd_rec.day;
         rsp_in.out_month          = rd_rec.month;
         rsp_in.out_sample_raw     = rd_rec.sample_raw;
         rsp_in.out_sample_percent = rd_rec.sample_percent;
      end
      rsp_in.valid_count = 7'(pend_count_ff);
      rsp_in.log_empty   = pend_read_ff && pend_empty_ff;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.valid_count <= 7'(LOG_DEPTH)))
      else $error("valid count above ring depth");

   // an empty read reports a zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.log_empty) |-> (rsp_ff.valid_count == 7'd0))
      else $error("empty flag with nonzero count");

   // a stalled pending request is kept
   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !rsp_free) |=> pend_ff)
      else $error("pending request lost while output stalled");

   // memory write and read never issue together
   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("memory write and read in the same cycle");
`endif

endmodule
